// File: design/lca_pkg.sv
package lca_pkg;

	localparam int NODE_W  = 10;
	localparam int DEPTH_W = 10;
	localparam int LEN_W   = 11;
	localparam int CNT_W   = 11;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [CNT_W-1:0]   count_t;

	typedef enum logic [1:0] {
		REQ_EDGE  = 2'd0,
		REQ_BUILD = 2'd1,
		REQ_LCA   = 2'd2,
		REQ_DIST  = 2'd3
	} req_kind_t;

endpackage

// File: design/lca_if.sv
interface lca_req_if;
	logic              valid;
	logic              ready;
	lca_pkg::req_kind_t req_type;
	lca_pkg::node_t    node_a;
	lca_pkg::node_t    node_b;

	modport source (output valid, output req_type, output node_a, output node_b, input ready);
	modport sink (input valid, input req_type, input node_a, input node_b, output ready);
endinterface

interface lca_rsp_if;
	logic           valid;
	logic           ready;
	lca_pkg::node_t ancestor_node;
	lca_pkg::len_t  path_length;

	modport source (output valid, output ancestor_node, output path_length, input ready);
	modport sink (input valid, input ancestor_node, input path_length, output ready);
endinterface

interface lca_cfg_if;
	logic            valid;
	logic            ready;
	lca_pkg::count_t node_count;

	modport source (output valid, output node_count, input ready);
	modport sink (input valid, input node_count, output ready);
endinterface

// File: design/lca_ram.sv
module lca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/tree_lca_binary_lifting.sv
// Lowest common ancestor engine with binary lifting tables.
// Words enter on req: add edge, build from a root, lca query or distance query.
// Only queries return a word on rsp; edge and build words return nothing.
// The cfg channel writes node_count, which clears the edges and all tables.
// The per-node table row (visited bit, depth and all ancestor levels) lives in one
// single-port-read RAM, and each table step of the sequencer waits on its registered read.
// A query reads its rows one at a time through that RAM port on its way from acceptance
// to the output register.
// A build first sweeps MAX_NODES rows clear, then for every reached node fills its
// ancestor levels and scans every stored edge for unvisited neighbours.
// After reset, and after every node_count write, a clearing pass over all MAX_NODES rows
// runs and req is not ready meanwhile. A result sits in an output register; a new
// word is taken while it waits, and only a second finished result waits on rsp.ready.
module tree_lca_binary_lifting #(
	parameter int MAX_NODES   = 1024,
	parameter int LIFT_LEVELS = 11
) (
	input  logic      clk,
	input  logic      arst_n,
	lca_cfg_if.sink   cfg,
	lca_req_if.sink   req,
	lca_rsp_if.source rsp
);

	localparam int NW       = lca_pkg::NODE_W;
	localparam int DW       = lca_pkg::DEPTH_W;
	localparam int NAW      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EDGE_CAP = MAX_NODES - 1;
	localparam int EAW      = (EDGE_CAP > 1) ? $clog2(EDGE_CAP) : 1;
	localparam int ECW      = $clog2(MAX_NODES);
	localparam int TW       = $clog2(MAX_NODES + 1);
	localparam int JW       = $clog2(LIFT_LEVELS + 1);
	localparam int LW       = $clog2(LIFT_LEVELS);
	localparam int NCW      = (lca_pkg::CNT_W > TW) ? lca_pkg::CNT_W : TW;
	localparam int NS       = 25;

	typedef struct packed {
		logic                        vis;
		lca_pkg::depth_t             depth;
		logic [LIFT_LEVELS-1:0][NW-1:0] anc;
	} row_t;

	typedef enum logic [NS-1:0] {
		S_CLEAR = NS'(1) << 0,
		S_IDLE  = NS'(1) << 1,
		B_ROOT  = NS'(1) << 2,
		B_POP   = NS'(1) << 3,
		B_POPW  = NS'(1) << 4,
		B_VROW  = NS'(1) << 5,
		B_LVL   = NS'(1) << 6,
		B_LVLW  = NS'(1) << 7,
		B_VWR   = NS'(1) << 8,
		B_EDGE  = NS'(1) << 9,
		B_EDGEW = NS'(1) << 10,
		B_VIS   = NS'(1) << 11,
		Q_RA    = NS'(1) << 12,
		Q_RB    = NS'(1) << 13,
		Q_SW    = NS'(1) << 14,
		Q_UP    = NS'(1) << 15,
		Q_UPW   = NS'(1) << 16,
		Q_EQ    = NS'(1) << 17,
		Q_DN    = NS'(1) << 18,
		Q_DNA   = NS'(1) << 19,
		Q_DNB   = NS'(1) << 20,
		Q_FIN   = NS'(1) << 21,
		Q_C     = NS'(1) << 22,
		Q_CW    = NS'(1) << 23,
		Q_OUT   = NS'(1) << 24
	} state_t;

	state_t              state_q;
	logic                build_q;
	logic [NAW-1:0]      clr_q;
	lca_pkg::count_t     node_count_q;
	logic [ECW-1:0]      edge_total_q;
	logic [ECW-1:0]      e_q;
	logic [TW-1:0]       top_q;
	logic [JW-1:0]       j_q;
	logic [LW-1:0]       lv_q;
	lca_pkg::node_t      v_q;
	lca_pkg::node_t      x_q;
	lca_pkg::node_t      w_q;
	lca_pkg::node_t      a_q;
	lca_pkg::node_t      b_q;
	lca_pkg::node_t      c_q;
	lca_pkg::req_kind_t  kind_q;
	row_t                row_q;
	row_t                rowb_q;
	lca_pkg::depth_t     k_q;
	lca_pkg::depth_t     da_q;
	lca_pkg::depth_t     db_q;
	lca_pkg::node_t      res_anc_q;
	lca_pkg::len_t       res_len_q;
	logic                out_valid_q;
	lca_pkg::node_t      out_anc_q;
	lca_pkg::len_t       out_len_q;

	logic                row_we;
	logic [NAW-1:0]      row_waddr;
	row_t                row_wdata;
	logic [NAW-1:0]      row_raddr;
	row_t                row_rdata;
	logic                stk_we;
	logic [NAW-1:0]      stk_waddr;
	lca_pkg::node_t      stk_wdata;
	logic [NAW-1:0]      stk_raddr;
	lca_pkg::node_t      stk_rdata;
	logic                edge_we;
	logic [EAW-1:0]      edge_waddr;
	logic [2*NW-1:0]     edge_wdata;
	logic [EAW-1:0]      edge_raddr;
	logic [2*NW-1:0]     edge_rdata;

	logic                req_acc;
	logic                cfg_acc;
	logic [NCW-1:0]      n_use;
	logic                a_ok;
	logic                b_ok;
	logic                edge_ok;
	logic [LW-1:0]       j_idx;
	logic [LW-1:0]       jm1_idx;
	row_t                xrow;
	lca_pkg::node_t      ea;
	lca_pkg::node_t      eb;
	logic                kbit;
	logic                differ;
	logic                can_push;
	logic                out_load;
	logic signed [DW+2:0] len_s;

	assign req_acc  = req.valid && req.ready;
	assign cfg_acc  = cfg.valid && cfg.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = (state_q == S_IDLE);

	assign n_use   = (NCW'(node_count_q) > NCW'(MAX_NODES)) ? NCW'(MAX_NODES)
		: NCW'(node_count_q);
	assign a_ok    = NCW'(req.node_a) < n_use;
	assign b_ok    = NCW'(req.node_b) < n_use;
	assign edge_ok = a_ok && b_ok && (edge_total_q < ECW'(EDGE_CAP));

	assign j_idx    = j_q[LW-1:0];
	assign jm1_idx  = LW'(j_q - JW'(1));
	assign xrow     = (x_q == v_q) ? row_q : row_rdata;
	assign ea       = edge_rdata[2*NW-1:NW];
	assign eb       = edge_rdata[NW-1:0];
	assign kbit     = |((k_q >> j_q) & DW'(1));
	assign differ   = row_q.anc[lv_q] != rowb_q.anc[lv_q];
	assign can_push = !row_rdata.vis && (top_q < TW'(MAX_NODES));
	assign out_load = (state_q == Q_OUT) && (!out_valid_q || rsp.ready);
	assign len_s    = (DW+3)'(da_q) + (DW+3)'(db_q) - ((DW+3)'(row_rdata.depth) << 1);

	always_comb begin
		row_we     = 1'b0;
		row_waddr  = '0;
		row_wdata  = '0;
		row_raddr  = '0;
		stk_we     = 1'b0;
		stk_waddr  = '0;
		stk_wdata  = '0;
		stk_raddr  = '0;
		edge_we    = 1'b0;
		edge_waddr = '0;
		edge_wdata = '0;
		edge_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				row_we    = 1'b1;
				row_waddr = clr_q;
			end
			S_IDLE: begin
				if (req_acc && (req.req_type == lca_pkg::REQ_EDGE) && edge_ok) begin
					edge_we    = 1'b1;
					edge_waddr = EAW'(edge_total_q);
					edge_wdata = {req.node_a, req.node_b};
				end
			end
			B_ROOT: begin
				row_we           = 1'b1;
				row_waddr        = NAW'(v_q);
				row_wdata.vis    = 1'b1;
				row_wdata.anc[0] = v_q;
				stk_we           = 1'b1;
				stk_wdata        = v_q;
			end
			B_POP: stk_raddr = NAW'(top_q - TW'(1));
			B_POPW: row_raddr = NAW'(stk_rdata);
			B_VROW: begin
			end
			B_LVL: row_raddr = NAW'(row_q.anc[jm1_idx]);
			B_LVLW: begin
			end
			B_VWR: begin
				row_we    = 1'b1;
				row_waddr = NAW'(v_q);
				row_wdata = row_q;
			end
			B_EDGE: edge_raddr = EAW'(e_q);
			B_EDGEW: row_raddr = NAW'((ea == v_q) ? eb : ea);
			B_VIS: begin
				if (can_push) begin
					row_we           = 1'b1;
					row_waddr        = NAW'(w_q);
					row_wdata.vis    = 1'b1;
					row_wdata.depth  = row_q.depth + DW'(1);
					row_wdata.anc[0] = v_q;
					stk_we           = 1'b1;
					stk_waddr        = NAW'(top_q);
					stk_wdata        = w_q;
				end
			end
			Q_RA: row_raddr = NAW'(a_q);
			Q_RB: row_raddr = NAW'(b_q);
			Q_SW: begin
			end
			Q_UP: row_raddr = NAW'(row_q.anc[j_idx]);
			Q_UPW: begin
			end
			Q_EQ: begin
			end
			Q_DN: row_raddr = NAW'(row_q.anc[lv_q]);
			Q_DNA: row_raddr = NAW'(b_q);
			Q_DNB: begin
			end
			Q_FIN: begin
			end
			Q_C: row_raddr = NAW'(c_q);
			Q_CW: begin
			end
			Q_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			build_q      <= 1'b0;
			clr_q        <= '0;
			node_count_q <= '0;
			edge_total_q <= '0;
			top_q        <= '0;
			e_q          <= '0;
			j_q          <= '0;
			lv_q         <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NAW'(1);
					if (clr_q == NAW'(MAX_NODES - 1)) begin
						state_q <= build_q ? B_ROOT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (cfg_acc) begin
						node_count_q <= cfg.node_count;
						edge_total_q <= '0;
						clr_q        <= '0;
						build_q      <= 1'b0;
						state_q      <= S_CLEAR;
					end else if (req_acc) begin
						unique case (req.req_type)
							lca_pkg::REQ_EDGE: begin
								if (edge_ok) begin
									edge_total_q <= edge_total_q + ECW'(1);
								end
							end
							lca_pkg::REQ_BUILD: begin
								if (a_ok) begin
									clr_q   <= '0;
									build_q <= 1'b1;
									state_q <= S_CLEAR;
								end
							end
							lca_pkg::REQ_LCA, lca_pkg::REQ_DIST: begin
								state_q <= (a_ok && b_ok) ? Q_RA : Q_OUT;
							end
							default: begin
							end
						endcase
					end
				end
				B_ROOT: begin
					top_q   <= TW'(1);
					state_q <= B_POP;
				end
				B_POP: begin
					if (top_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						top_q   <= top_q - TW'(1);
						state_q <= B_POPW;
					end
				end
				B_POPW: state_q <= B_VROW;
				B_VROW: begin
					j_q     <= JW'(1);
					state_q <= B_LVL;
				end
				B_LVL: state_q <= B_LVLW;
				B_LVLW: begin
					j_q     <= j_q + JW'(1);
					state_q <= (j_q == JW'(LIFT_LEVELS - 1)) ? B_VWR : B_LVL;
				end
				B_VWR: begin
					e_q     <= '0;
					state_q <= B_EDGE;
				end
				B_EDGE: begin
					if (e_q == edge_total_q) begin
						state_q <= B_POP;
					end else begin
						e_q     <= e_q + ECW'(1);
						state_q <= B_EDGEW;
					end
				end
				B_EDGEW: begin
					state_q <= ((ea == v_q) || (eb == v_q)) ? B_VIS : B_EDGE;
				end
				B_VIS: begin
					if (can_push) begin
						top_q <= top_q + TW'(1);
					end
					state_q <= B_EDGE;
				end
				Q_RA: state_q <= Q_RB;
				Q_RB: state_q <= Q_SW;
				Q_SW: begin
					j_q     <= '0;
					state_q <= Q_UP;
				end
				Q_UP: begin
					if (j_q == JW'(LIFT_LEVELS)) begin
						state_q <= Q_EQ;
					end else begin
						j_q <= j_q + JW'(1);
						if (kbit) begin
							state_q <= Q_UPW;
						end
					end
				end
				Q_UPW: state_q <= Q_UP;
				Q_EQ: begin
					lv_q    <= LW'(LIFT_LEVELS - 1);
					state_q <= (a_q == b_q) ? Q_C : Q_DN;
				end
				Q_DN: begin
					if (differ) begin
						state_q <= Q_DNA;
					end else if (lv_q == '0) begin
						state_q <= Q_FIN;
					end else begin
						lv_q <= lv_q - LW'(1);
					end
				end
				Q_DNA: state_q <= Q_DNB;
				Q_DNB: begin
					if (lv_q == '0) begin
						state_q <= Q_FIN;
					end else begin
						lv_q    <= lv_q - LW'(1);
						state_q <= Q_DN;
					end
				end
				Q_FIN: state_q <= Q_C;
				Q_C: state_q <= Q_CW;
				Q_CW: state_q <= Q_OUT;
				Q_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					v_q       <= req.node_a;
					a_q       <= req.node_a;
					b_q       <= req.node_b;
					kind_q    <= req.req_type;
					res_anc_q <= '0;
					res_len_q <= '0;
				end
			end
			B_POPW: v_q <= stk_rdata;
			B_VROW: row_q <= row_rdata;
			B_LVL: x_q <= row_q.anc[jm1_idx];
			B_LVLW: row_q.anc[j_idx] <= xrow.anc[jm1_idx];
			B_EDGEW: w_q <= (ea == v_q) ? eb : ea;
			Q_RB: row_q <= row_rdata;
			Q_SW: begin
				da_q <= row_q.depth;
				db_q <= row_rdata.depth;
				if (row_q.depth < row_rdata.depth) begin
					a_q    <= b_q;
					b_q    <= a_q;
					row_q  <= row_rdata;
					rowb_q <= row_q;
					k_q    <= row_rdata.depth - row_q.depth;
				end else begin
					rowb_q <= row_rdata;
					k_q    <= row_q.depth - row_rdata.depth;
				end
			end
			Q_UP: begin
				if ((j_q != JW'(LIFT_LEVELS)) && kbit) begin
					a_q <= row_q.anc[j_idx];
				end
			end
			Q_UPW: row_q <= row_rdata;
			Q_EQ: c_q <= a_q;
			Q_DN: begin
				if (differ) begin
					b_q <= rowb_q.anc[lv_q];
				end
			end
			Q_DNA: row_q <= row_rdata;
			Q_DNB: rowb_q <= row_rdata;
			Q_FIN: c_q <= row_q.anc[0];
			Q_CW: begin
				res_anc_q <= c_q;
				if ((kind_q == lca_pkg::REQ_DIST) && !len_s[DW+2]) begin
					res_len_q <= lca_pkg::LEN_W'(len_s);
				end else begin
					res_len_q <= '0;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_anc_q <= res_anc_q;
			out_len_q <= res_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.ancestor_node = out_anc_q;
	assign rsp.path_length   = out_len_q;

	lca_ram #(.WIDTH($bits(row_t)), .DEPTH(MAX_NODES)) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	lca_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	lca_ram #(.WIDTH(2 * NW), .DEPTH(EDGE_CAP)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edge_waddr),
		.wdata (edge_wdata),
		.raddr (edge_raddr),
		.rdata (edge_rdata)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= ECW'(EDGE_CAP))
		else $error("Edge count exceeds the edge store capacity.");

	assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TW'(MAX_NODES))
		else $error("Walk stack pointer exceeds the stack depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(req.ready || cfg.ready) |-> (state_q == S_IDLE))
		else $error("Input taken while the sequencer is busy.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (kind_q == lca_pkg::REQ_LCA)) |=> (rsp.path_length == '0))
		else $error("An lca query returned a nonzero path length.");

endmodule
